FILE: src/rcdd_pkg.sv
`timescale 1ns / 1ps

package rcdd_pkg;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  localparam int PulseW = 11;
  localparam logic [15:0] PULSE_MIN = 16'd1000;
  localparam logic [15:0] PULSE_MAX = 16'd2000;
  localparam logic [PulseW-1:0] PULSE_NEUTRAL = 11'd1500;
  localparam logic [PulseW-1:0] DEAD_LOW      = 11'd1450;
  localparam logic [PulseW-1:0] DEAD_HIGH     = 11'd1550;
  localparam logic [PulseW-1:0] THR_ORIGIN    = 11'd1100;
  localparam logic [PulseW-1:0] STR_ORIGIN    = 11'd1000;

  // Constant division by reciprocal multiply: q = (n * RECIP_d) >> RECIP_SHIFT
  localparam int RECIP_SHIFT = 20;
  localparam int RecipW      = 18;
  localparam logic [RecipW-1:0] RECIP_5   = 18'd209716;
  localparam logic [RecipW-1:0] RECIP_7   = 18'd149797;
  localparam logic [RecipW-1:0] RECIP_9   = 18'd116509;
  localparam logic [RecipW-1:0] RECIP_100 = 18'd10486;

  localparam int ALPHA_SHIFT = 8;

  localparam logic [7:0] CAP_MAX = 8'd150;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TIMEOUT  = 2'd0,
    CFG_INTERVAL = 2'd1,
    CFG_ALPHA    = 2'd2
  } cfg_index_e;

  typedef struct packed {
    logic [15:0] steering_pulse_us;
    logic [15:0] throttle_pulse_us;
    logic [31:0] now_ms;
    logic [14:0] front_echo_us;
    logic [14:0] left_echo_us;
    logic [14:0] right_echo_us;
  } mixer_in_t;

  typedef struct packed {
    logic [7:0] left_forward_duty;
    logic [6:0] left_reverse_duty;
    logic [7:0] right_forward_duty;
    logic [6:0] right_reverse_duty;
    logic       link_valid;
    logic [7:0] speed_limit;
  } mixer_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HOLD,
    ST_THR,
    ST_STR,
    ST_MIX,
    ST_DIV,
    ST_CLAMP,
    ST_FILT_L,
    ST_FILT_R,
    ST_UPD_R,
    ST_FINISH
  } ctrl_state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_HOLD,
    OP_THR,
    OP_STR,
    OP_MIX,
    OP_DIV,
    OP_CLAMP,
    OP_FILT_L,
    OP_FILT_R,
    OP_UPD_R,
    OP_LOAD_OUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic out_full;
  } dp_status_t;

  function automatic logic pulse_ok(input logic [15:0] p);
    return (p >= PULSE_MIN) && (p <= PULSE_MAX);
  endfunction

  // e * 17 against 10000/25000/50000/100000, folded into echo thresholds
  function automatic logic [7:0] cap_from_echoes(input logic [14:0] e0,
                                                 input logic [14:0] e1,
                                                 input logic [14:0] e2);
    logic [14:0] nearest;
    logic [7:0]  cap;
    nearest = e0;
    if (e1 != 15'd0 && (nearest == 15'd0 || e1 < nearest)) nearest = e1;
    if (e2 != 15'd0 && (nearest == 15'd0 || e2 < nearest)) nearest = e2;
    if (nearest == 15'd0)         cap = CAP_MAX;
    else if (nearest <= 15'd588)  cap = 8'd0;
    else if (nearest <= 15'd1470) cap = 8'd30;
    else if (nearest <= 15'd2941) cap = 8'd60;
    else if (nearest <= 15'd5882) cap = 8'd105;
    else                          cap = CAP_MAX;
    return cap;
  endfunction

endpackage

FILE: src/rc_differential_drive_mixer.sv
`timescale 1ns / 1ps

// RC differential-drive mixer with ultrasonic speed capping.
// Input channel: in_valid_i / in_stall_o carry one control tick (pulse widths,
// ms timestamp, three echo times) per transfer. Output channel: out_valid_o /
// out_stall_i carry one result (four duty values, link flag, speed cap) per
// tick. Configuration: cfg_we_i writes cfg_wdata_i into register cfg_index_i
// (0 timeout, 1 cap refresh interval, 2 filter alpha); write only while idle.
// Each tick runs HOLD, THR, STR, MIX, DIV, CLAMP, FILT_L, FILT_R, UPD_R, FINISH
// in turn; FINISH loads the result. One tick is worked at a time through a
// sequencer sharing a single multiplier; the next is taken once back in idle.
// A finished result sits in the output register; the next tick is accepted
// meanwhile and is held in its last step until the receiver takes the
// previous result. Stalling the output never drops or repeats a result.
// Reset restores the default configuration, neutral held pulses, link down,
// full speed cap and zeroed filters; no clearing pass is needed.
module rc_differential_drive_mixer
  import rcdd_pkg::*;
#(
  parameter int FILTER_FRACTION_BITS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mixer_in_t           in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mixer_out_t          out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  dp_cmd_t    cmd;
  dp_status_t status;

  rcdd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rcdd_datapath #(
    .FILTER_FRACTION_BITS (FILTER_FRACTION_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

endmodule

FILE: src/rcdd_ctrl.sv
`timescale 1ns / 1ps

module rcdd_ctrl
  import rcdd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_HOLD;
      ST_HOLD:   state_d = ST_THR;
      ST_THR:    state_d = ST_STR;
      ST_STR:    state_d = ST_MIX;
      ST_MIX:    state_d = ST_DIV;
      ST_DIV:    state_d = ST_CLAMP;
      ST_CLAMP:  state_d = ST_FILT_L;
      ST_FILT_L: state_d = ST_FILT_R;
      ST_FILT_R: state_d = ST_UPD_R;
      ST_UPD_R:  state_d = ST_FINISH;
      ST_FINISH: if (!status_i.out_full) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    cmd_o.op   = OP_NONE;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) cmd_o.op = OP_CAPTURE;
      end
      ST_HOLD:   cmd_o.op = OP_HOLD;
      ST_THR:    cmd_o.op = OP_THR;
      ST_STR:    cmd_o.op = OP_STR;
      ST_MIX:    cmd_o.op = OP_MIX;
      ST_DIV:    cmd_o.op = OP_DIV;
      ST_CLAMP:  cmd_o.op = OP_CLAMP;
      ST_FILT_L: cmd_o.op = OP_FILT_L;
      ST_FILT_R: cmd_o.op = OP_FILT_R;
      ST_UPD_R:  cmd_o.op = OP_UPD_R;
      ST_FINISH: if (!status_i.out_full) cmd_o.op = OP_LOAD_OUT;
      default:   cmd_o.op = OP_NONE;
    endcase
  end

endmodule

FILE: src/rcdd_datapath.sv
`timescale 1ns / 1ps

module rcdd_datapath
  import rcdd_pkg::*;
#(
  parameter int FILTER_FRACTION_BITS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dp_cmd_t             cmd_i,
  output dp_status_t          status_o,
  input  mixer_in_t           in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mixer_out_t          out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  localparam int F  = FILTER_FRACTION_BITS;
  localparam int FW = F + 9;                      // filtered speed, signed
  localparam int AW = (F + 8 > 15) ? F + 8 : 15;  // multiplier A operand
  localparam int PW = AW + RecipW;
  localparam int RS = RECIP_SHIFT;

  // configuration
  logic [15:0] timeout_q;
  logic [9:0]  interval_q;
  logic [7:0]  alpha_q;

  // block state
  logic [PulseW-1:0] held_str_q, held_thr_q;
  logic [31:0]       last_valid_q, last_meas_q;
  logic              link_q;
  logic [7:0]        cap_q;
  logic signed [FW-1:0] fl_q, fr_q;

  // per-item working registers
  mixer_in_t          in_q;
  logic [PW-1:0]      p_q;
  logic signed [8:0]  base_q;
  logic signed [7:0]  steer_q;
  logic signed [8:0]  left_q, right_q;
  mixer_out_t         out_q;
  logic               out_valid_q;

  // ---------------- hold / cap refresh ----------------
  logic        both_ok, timed_out, refresh;
  logic [31:0] dt_valid, dt_meas;

  assign both_ok   = pulse_ok(in_q.steering_pulse_us) && pulse_ok(in_q.throttle_pulse_us);
  assign dt_valid  = in_q.now_ms - last_valid_q;
  assign dt_meas   = in_q.now_ms - last_meas_q;
  assign timed_out = dt_valid > {16'd0, timeout_q};
  assign refresh   = dt_meas >= {22'd0, interval_q};

  // ---------------- throttle / steering maps ----------------
  logic              thr_low, thr_high, thr_neg;
  logic signed [11:0] thr_x;
  logic [11:0]       thr_mag, thr_hi_n, thr_hi3;
  logic              str_low, str_high;
  logic [PulseW-1:0] str_lo_n, str_hi_n;

  assign thr_low  = held_thr_q < DEAD_LOW;
  assign thr_high = held_thr_q > DEAD_HIGH;
  assign thr_x    = $signed({1'b0, held_thr_q}) - $signed({1'b0, THR_ORIGIN});
  assign thr_neg  = thr_x[11];
  assign thr_mag  = thr_neg ? 12'(-thr_x) : 12'(thr_x);
  assign thr_hi_n = 12'(held_thr_q - DEAD_HIGH);
  assign thr_hi3  = (thr_hi_n << 1) + thr_hi_n;

  assign str_low  = held_str_q < DEAD_LOW;
  assign str_high = held_str_q > DEAD_HIGH;
  assign str_lo_n = held_str_q - STR_ORIGIN;
  assign str_hi_n = held_str_q - DEAD_HIGH;

  logic signed [9:0] q_t_s, base_d;
  logic [6:0]        q_s, steer_abs, factor;
  logic signed [7:0] steer_d;
  logic [7:0]        base_abs;

  assign q_t_s = $signed({2'b00, p_q[RS +: 8]});
  assign q_s   = p_q[RS +: 7];

  always_comb begin
    if (thr_low) begin
      base_d = (thr_neg ? -q_t_s : q_t_s) - 10'sd70;
    end else if (thr_high) begin
      base_d = q_t_s;
    end else begin
      base_d = '0;
    end
  end

  always_comb begin
    if (str_low) begin
      steer_d   = $signed({1'b0, q_s}) - 8'sd100;
      steer_abs = 7'd100 - q_s;
    end else if (str_high) begin
      steer_d   = $signed({1'b0, q_s});
      steer_abs = q_s;
    end else begin
      steer_d   = '0;
      steer_abs = '0;
    end
  end

  assign factor   = 7'd100 - steer_abs;
  assign base_abs = base_q[8] ? 8'(-base_q) : base_q[7:0];

  // ---------------- mix and clamp ----------------
  function automatic logic signed [8:0] clamp_speed(input logic signed [9:0] v,
                                                    input logic [7:0] cap);
    logic signed [9:0] r;
    if (v > 10'sd0) begin
      r = (v > $signed({2'b00, cap})) ? $signed({2'b00, cap}) : v;
    end else begin
      r = (v < -10'sd70) ? -10'sd70 : v;
    end
    return r[8:0];
  endfunction

  logic [7:0]        mix_mag;
  logic signed [9:0] mixed, base_ext, left_raw, right_raw;

  assign mix_mag   = p_q[RS +: 8];
  assign mixed     = base_q[8] ? -$signed({2'b00, mix_mag}) : $signed({2'b00, mix_mag});
  assign base_ext  = {base_q[8], base_q};
  assign left_raw  = (steer_q < 8'sd0) ? mixed : base_ext;
  assign right_raw = (steer_q > 8'sd0) ? mixed : base_ext;

  // ---------------- acceleration filter ----------------
  logic signed [FW-1:0] tgt_l, tgt_r;
  logic signed [FW:0]   diff_l, diff_r;
  logic [FW:0]          dmag_l, dmag_r;
  logic [FW-1:0]        tabs_l, tabs_r, fabs_l, fabs_r, step;
  logic                 grow_l, grow_r;
  logic [FW-1:0]        fl_next, fr_next;

  assign tgt_l  = $signed({left_q, {F{1'b0}}});
  assign tgt_r  = $signed({right_q, {F{1'b0}}});
  assign diff_l = {tgt_l[FW-1], tgt_l} - {fl_q[FW-1], fl_q};
  assign diff_r = {tgt_r[FW-1], tgt_r} - {fr_q[FW-1], fr_q};
  assign dmag_l = diff_l[FW] ? (~diff_l + 1'b1) : diff_l;
  assign dmag_r = diff_r[FW] ? (~diff_r + 1'b1) : diff_r;
  assign tabs_l = tgt_l[FW-1] ? (~tgt_l + 1'b1) : tgt_l;
  assign tabs_r = tgt_r[FW-1] ? (~tgt_r + 1'b1) : tgt_r;
  assign fabs_l = fl_q[FW-1] ? (~fl_q + 1'b1) : fl_q;
  assign fabs_r = fr_q[FW-1] ? (~fr_q + 1'b1) : fr_q;
  assign grow_l = tabs_l > fabs_l;
  assign grow_r = tabs_r > fabs_r;
  assign step   = p_q[ALPHA_SHIFT +: FW];

  // step is the magnitude, so adding or subtracting it truncates toward zero
  assign fl_next = grow_l ? (diff_l[FW] ? fl_q - step : fl_q + step) : tgt_l;
  assign fr_next = grow_r ? (diff_r[FW] ? fr_q - step : fr_q + step) : tgt_r;

  // ---------------- shared multiplier ----------------
  logic [AW-1:0]     mul_a;
  logic [RecipW-1:0] mul_b;
  logic [PW-1:0]     product;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.op)
      OP_THR: begin
        mul_a = thr_low ? AW'(thr_mag) : (thr_high ? AW'(thr_hi3) : '0);
        mul_b = thr_low ? RECIP_5 : RECIP_7;
      end
      OP_STR: begin
        mul_a = str_low ? AW'({str_lo_n, 1'b0}) : (str_high ? AW'({str_hi_n, 1'b0}) : '0);
        mul_b = RECIP_9;
      end
      OP_MIX: begin
        mul_a = AW'(base_abs);
        mul_b = RecipW'(factor);
      end
      OP_DIV: begin
        mul_a = AW'(p_q[14:0]);
        mul_b = RECIP_100;
      end
      OP_FILT_L: begin
        mul_a = AW'(dmag_l);
        mul_b = RecipW'(alpha_q);
      end
      OP_FILT_R: begin
        mul_a = AW'(dmag_r);
        mul_b = RecipW'(alpha_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign product = PW'(mul_a) * PW'(mul_b);

  // ---------------- output split ----------------
  logic [FW-1:0] mag_l, mag_r;
  logic [7:0]    duty_l, duty_r;

  assign mag_l  = fabs_l >> F;
  assign mag_r  = fabs_r >> F;
  assign duty_l = mag_l[7:0];
  assign duty_r = mag_r[7:0];

  logic load_out;
  assign load_out = cmd_i.op == OP_LOAD_OUT;

  // ---------------- payload registers ----------------
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_CAPTURE) in_q <= in_data_i;
    if (cmd_i.op == OP_THR || cmd_i.op == OP_STR || cmd_i.op == OP_MIX ||
        cmd_i.op == OP_DIV || cmd_i.op == OP_FILT_L || cmd_i.op == OP_FILT_R) begin
      p_q <= product;
    end
    if (cmd_i.op == OP_STR) base_q <= base_d[8:0];
    if (cmd_i.op == OP_MIX) steer_q <= steer_d;
    if (cmd_i.op == OP_CLAMP) begin
      left_q  <= clamp_speed(left_raw, cap_q);
      right_q <= clamp_speed(right_raw, cap_q);
    end
    if (load_out) begin
      out_q.left_forward_duty  <= fl_q[FW-1] ? 8'd0 : duty_l;
      out_q.left_reverse_duty  <= fl_q[FW-1] ? duty_l[6:0] : 7'd0;
      out_q.right_forward_duty <= fr_q[FW-1] ? 8'd0 : duty_r;
      out_q.right_reverse_duty <= fr_q[FW-1] ? duty_r[6:0] : 7'd0;
      out_q.link_valid         <= link_q;
      out_q.speed_limit        <= cap_q;
    end
  end

  // ---------------- state and configuration ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q    <= 16'd200;
      interval_q   <= 10'd50;
      alpha_q      <= 8'd38;
      held_str_q   <= PULSE_NEUTRAL;
      held_thr_q   <= PULSE_NEUTRAL;
      last_valid_q <= '0;
      last_meas_q  <= '0;
      link_q       <= 1'b0;
      cap_q        <= CAP_MAX;
      fl_q         <= '0;
      fr_q         <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_e'(cfg_index_i))
          CFG_TIMEOUT:  timeout_q  <= cfg_wdata_i;
          CFG_INTERVAL: interval_q <= cfg_wdata_i[9:0];
          CFG_ALPHA:    alpha_q    <= cfg_wdata_i[7:0];
          default: ;
        endcase
      end
      if (cmd_i.op == OP_HOLD) begin
        if (both_ok) begin
          held_str_q   <= in_q.steering_pulse_us[PulseW-1:0];
          held_thr_q   <= in_q.throttle_pulse_us[PulseW-1:0];
          last_valid_q <= in_q.now_ms;
          link_q       <= 1'b1;
        end else if (timed_out) begin
          held_str_q <= PULSE_NEUTRAL;
          held_thr_q <= PULSE_NEUTRAL;
          link_q     <= 1'b0;
        end
        if (refresh) begin
          last_meas_q <= in_q.now_ms;
          cap_q <= cap_from_echoes(in_q.front_echo_us, in_q.left_echo_us,
                                   in_q.right_echo_us);
        end
      end
      if (cmd_i.op == OP_FILT_R) fl_q <= fl_next;
      if (cmd_i.op == OP_UPD_R)  fr_q <= fr_next;
      out_valid_q <= load_out | (out_valid_q & out_stall_i);
    end
  end

  assign status_o.out_full = out_valid_q & out_stall_i;
  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_q;

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import rcdd_pkg::*;

  localparam int FracBits      = 8;
  localparam int WatchdogLimit = 4000;
  localparam int RandomTicks   = 1400;
  localparam int Phases        = 7;
  localparam int HoldOffCycles = 150;
  localparam logic [CfgIdxW-1:0] CFG_UNUSED = 2'd3;

  class mixer_scoreboard;
    logic [15:0] timeout_ms;
    logic [9:0]  interval_ms;
    logic [7:0]  alpha;
    logic [10:0] held_steer;
    logic [10:0] held_thr;
    logic [31:0] last_valid_ms;
    logic [31:0] last_measure_ms;
    logic        link_up;
    int          cap;
    longint      filt_left;
    longint      filt_right;
    mixer_out_t  expected_q[$];
    int          failures;

    function new();
      timeout_ms      = 16'd200;
      interval_ms     = 10'd50;
      alpha           = 8'd38;
      held_steer      = 11'd1500;
      held_thr        = 11'd1500;
      last_valid_ms   = '0;
      last_measure_ms = '0;
      link_up         = 1'b0;
      cap             = 150;
      filt_left       = 0;
      filt_right      = 0;
      failures        = 0;
    endfunction

    function void set_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      case (idx)
        CFG_TIMEOUT:  timeout_ms = val;
        CFG_INTERVAL: interval_ms = val[9:0];
        CFG_ALPHA:    alpha = val[7:0];
        default: ;
      endcase
    endfunction

    function bit pulse_valid(logic [15:0] p);
      return p >= 16'd1000 && p <= 16'd2000;
    endfunction

    // nearest non-zero echo; distance compared as e*17 against cm*1000
    function int echo_cap(logic [14:0] e0, logic [14:0] e1, logic [14:0] e2);
      logic [14:0] echoes[3];
      logic [14:0] nearest;
      longint      scaled;
      echoes  = '{e0, e1, e2};
      nearest = '0;
      foreach (echoes[i])
        if (echoes[i] != 0 && (nearest == 0 || echoes[i] < nearest)) nearest = echoes[i];
      if (nearest == 0) return 150;
      scaled = longint'(nearest) * 17;
      if (scaled <= 10000) return 0;
      if (scaled <= 25000) return 30;
      if (scaled <= 50000) return 60;
      if (scaled <= 100000) return 105;
      return 150;
    endfunction

    function int speed_clamp(int v);
      if (v > 0) return (v > cap) ? cap : v;
      return (v < -70) ? -70 : v;
    endfunction

    // accelerate-only smoothing; any drop in magnitude snaps to target
    function longint smooth_speed(longint f, int speed);
      longint target;
      longint mag_t;
      longint mag_f;
      target = longint'(speed) * (longint'(1) <<< FracBits);
      mag_t  = (target < 0) ? -target : target;
      mag_f  = (f < 0) ? -f : f;
      if (mag_t > mag_f) return f + (longint'(alpha) * (target - f)) / 256;
      return target;
    endfunction

    function void duty_from_speed(longint f, output logic [7:0] fwd, output logic [6:0] rev);
      longint whole;
      longint neg;
      whole = f / (longint'(1) <<< FracBits);
      neg   = -whole;
      fwd   = (whole > 0) ? whole[7:0] : 8'd0;
      rev   = (whole < 0) ? neg[6:0] : 7'd0;
    endfunction

    function void note_tick(mixer_in_t d);
      int          thr;
      int          str;
      int          base;
      int          steer;
      int          left;
      int          right;
      logic [31:0] since;
      logic [7:0]  lf;
      logic [6:0]  lr;
      logic [7:0]  rf;
      logic [6:0]  rr;
      mixer_out_t  e;
      since = d.now_ms - last_valid_ms;
      if (pulse_valid(d.steering_pulse_us) && pulse_valid(d.throttle_pulse_us)) begin
        held_steer    = d.steering_pulse_us[10:0];
        held_thr      = d.throttle_pulse_us[10:0];
        last_valid_ms = d.now_ms;
        link_up       = 1'b1;
      end else if (since > 32'(timeout_ms)) begin
        held_steer = 11'd1500;
        held_thr   = 11'd1500;
        link_up    = 1'b0;
      end

      thr = int'(held_thr);
      if (thr < 1450) base = (thr - 1100) * 70 / 350 - 70;
      else if (thr > 1550) base = (thr - 1550) * 150 / 350;
      else base = 0;

      str = int'(held_steer);
      if (str < 1450) steer = (str - 1000) * 100 / 450 - 100;
      else if (str > 1550) steer = (str - 1550) * 100 / 450;
      else steer = 0;

      left  = base;
      right = base;
      if (steer > 0) right = base * (100 - steer) / 100;
      else if (steer < 0) left = base * (100 + steer) / 100;

      since = d.now_ms - last_measure_ms;
      if (since >= 32'(interval_ms)) begin
        last_measure_ms = d.now_ms;
        cap = echo_cap(d.front_echo_us, d.left_echo_us, d.right_echo_us);
      end

      filt_left  = smooth_speed(filt_left, speed_clamp(left));
      filt_right = smooth_speed(filt_right, speed_clamp(right));
      duty_from_speed(filt_left, lf, lr);
      duty_from_speed(filt_right, rf, rr);
      e.left_forward_duty  = lf;
      e.left_reverse_duty  = lr;
      e.right_forward_duty = rf;
      e.right_reverse_duty = rr;
      e.link_valid         = link_up;
      e.speed_limit        = cap[7:0];
      expected_q.push_back(e);
    endfunction

    function bit field_ok(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function void check_result(mixer_out_t got);
      mixer_out_t want;
      bit         ok;
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing outstanding, expected none, actual %h", $time, got);
        failures++;
        return;
      end
      want = expected_q.pop_front();
      ok = field_ok("left_forward_duty", want.left_forward_duty, got.left_forward_duty)
         & field_ok("left_reverse_duty", 8'(want.left_reverse_duty),
                    8'(got.left_reverse_duty))
         & field_ok("right_forward_duty", want.right_forward_duty, got.right_forward_duty)
         & field_ok("right_reverse_duty", 8'(want.right_reverse_duty),
                    8'(got.right_reverse_duty))
         & field_ok("link_valid", 8'(want.link_valid), 8'(got.link_valid))
         & field_ok("speed_limit", want.speed_limit, got.speed_limit);
      if (!ok) failures++;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  mixer_in_t           in_data_i;
  logic                out_valid_o;
  logic                out_stall_i;
  mixer_out_t          out_data_o;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  mixer_scoreboard sb;
  logic [31:0]     clock_ms  = 32'd32;
  int              loss_left = 0;
  bit              calm      = 1'b0;
  int              hold_left = 0;

  rc_differential_drive_mixer #(
    .FILTER_FRACTION_BITS(FracBits)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [15:0] valid_pulse();
    logic [15:0] edges[11] = '{16'd1000, 16'd2000, 16'd1449, 16'd1450, 16'd1451, 16'd1549,
                               16'd1550, 16'd1551, 16'd1500, 16'd1100, 16'd1099};
    if ($urandom_range(0, 9) == 0) return edges[$urandom_range(0, 10)];
    return 16'($urandom_range(1000, 2000));
  endfunction

  function automatic logic [15:0] invalid_pulse();
    case ($urandom_range(0, 5))
      0:       return 16'd0;
      1:       return 16'd999;
      2:       return 16'd2001;
      3:       return 16'($urandom_range(0, 999));
      4:       return 16'($urandom_range(2001, 65535));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [14:0] echo_value();
    logic [14:0] edges[15] = '{15'd1, 15'd587, 15'd588, 15'd589, 15'd1469, 15'd1470,
                               15'd1471, 15'd2940, 15'd2941, 15'd2942, 15'd5881, 15'd5882,
                               15'd5883, 15'd30000, 15'd32767};
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 15'd0;
    if (r < 45) return edges[$urandom_range(0, 14)];
    if (r < 75) return 15'($urandom_range(1, 6500));
    return 15'($urandom_range(0, 32767));
  endfunction

  // mostly a live link with runs of lost frames long enough to time out
  function automatic mixer_in_t random_tick();
    mixer_in_t d;
    int        r;
    r = $urandom_range(0, 99);
    if (r < 80) clock_ms = clock_ms + $urandom_range(0, 40);
    else if (r < 92) clock_ms = clock_ms + $urandom_range(41, 600);
    else if (r < 97) clock_ms = clock_ms + $urandom;
    else clock_ms = $urandom;
    d.now_ms = clock_ms;

    r = $urandom_range(0, 99);
    if (loss_left > 0) begin
      loss_left--;
      d.steering_pulse_us = invalid_pulse();
      d.throttle_pulse_us = (r < 70) ? invalid_pulse() : valid_pulse();
    end else begin
      if (r < 4) loss_left = $urandom_range(3, 25);
      d.steering_pulse_us = (r >= 80 && r < 90) ? invalid_pulse() : valid_pulse();
      d.throttle_pulse_us = (r >= 90) ? invalid_pulse() : valid_pulse();
    end
    d.front_echo_us = echo_value();
    d.left_echo_us  = echo_value();
    d.right_echo_us = echo_value();
    return d;
  endfunction

  function automatic mixer_in_t make_tick(int str, int thr, logic [31:0] now,
                                          int fe, int le, int re);
    mixer_in_t d;
    d.steering_pulse_us = 16'(str);
    d.throttle_pulse_us = 16'(thr);
    d.now_ms            = now;
    d.front_echo_us     = 15'(fe);
    d.left_echo_us      = 15'(le);
    d.right_echo_us     = 15'(re);
    return d;
  endfunction

  // called at a falling edge; returns at the falling edge after the transfer, or later after a random valid gap
  task automatic drive_tick(input mixer_in_t d);
    in_data_i  = d;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_tick(d);
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (12) @(negedge clk_i);
  endtask

  task automatic write_register(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_wdata_i = val;
    sb.set_register(idx, val);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic configure_phase(input int p);
    case (p)
      1: begin
        write_register(CFG_TIMEOUT, 16'd0);
        write_register(CFG_INTERVAL, 16'd0);
        write_register(CFG_ALPHA, 16'd0);
      end
      2: begin
        // upper bits beyond the interval and alpha register widths are dropped
        write_register(CFG_TIMEOUT, 16'hFFFF);
        write_register(CFG_INTERVAL, 16'hFFFF);
        write_register(CFG_ALPHA, 16'hFFFF);
      end
      3: begin
        write_register(CFG_TIMEOUT, 16'd1);
        write_register(CFG_INTERVAL, 16'd1023);
        write_register(CFG_ALPHA, 16'd255);
      end
      Phases: begin
        write_register(CFG_TIMEOUT, 16'd200);
        write_register(CFG_INTERVAL, 16'd50);
        write_register(CFG_ALPHA, 16'd38);
      end
      default: begin
        write_register(CFG_TIMEOUT, 16'($urandom_range(0, 400)));
        write_register(CFG_INTERVAL, 16'($urandom_range(0, 120)));
        write_register(CFG_ALPHA, 16'($urandom_range(1, 255)));
        write_register(CFG_UNUSED, 16'($urandom));
      end
    endcase
  endtask

  // receiver: short stall bursts, quiet stretches, and two long hold-offs
  initial begin
    int burst;
    int quiet;
    int seen;
    burst       = 0;
    quiet       = 0;
    seen        = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_stall_i = 1'b1;
        hold_left--;
      end else if (burst > 0) begin
        out_stall_i = 1'b1;
        burst--;
      end else if (quiet > 0 || calm) begin
        out_stall_i = 1'b0;
        if (quiet > 0) quiet--;
      end else if ($urandom_range(0, 3) == 0) begin
        out_stall_i = 1'b1;
        burst = $urandom_range(0, 2);
      end else begin
        out_stall_i = 1'b0;
        if ($urandom_range(0, 15) == 0) quiet = $urandom_range(10, 60);
      end
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        sb.check_result(out_data_o);
        seen++;
        if (seen == 150 || seen == 700) hold_left = HoldOffCycles;
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    mixer_in_t directed_q[$];
    sb          = new();
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_index_i = CFG_TIMEOUT;
    cfg_wdata_i = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // deadband edges, cap thresholds, failsafe timeout, reversal, clock wrap
    directed_q.push_back(make_tick(1500, 1500, 32'd0, 0, 0, 0));
    directed_q.push_back(make_tick(2000, 2000, 32'd60, 0, 0, 0));
    directed_q.push_back(make_tick(1000, 2000, 32'd70, 1, 0, 0));
    directed_q.push_back(make_tick(1551, 2000, 32'd120, 1, 589, 600));
    directed_q.push_back(make_tick(1449, 1000, 32'd200, 588, 0, 0));
    directed_q.push_back(make_tick(1450, 1100, 32'd260, 0, 589, 1470));
    directed_q.push_back(make_tick(1550, 1449, 32'd320, 1471, 0, 2000));
    directed_q.push_back(make_tick(1000, 1450, 32'd380, 2941, 2942, 0));
    directed_q.push_back(make_tick(2000, 1551, 32'd440, 0, 0, 2942));
    directed_q.push_back(make_tick(1500, 1550, 32'd500, 5882, 0, 0));
    directed_q.push_back(make_tick(1001, 1999, 32'd560, 5883, 30000, 32767));
    directed_q.push_back(make_tick(1500, 2001, 32'd600, 0, 0, 0));
    directed_q.push_back(make_tick(1500, 999, 32'd700, 0, 0, 0));
    directed_q.push_back(make_tick(0, 0, 32'd761, 0, 0, 0));
    directed_q.push_back(make_tick(65535, 2000, 32'd800, 0, 0, 0));
    directed_q.push_back(make_tick(2000, 65535, 32'd900, 0, 0, 0));
    directed_q.push_back(make_tick(1500, 2000, 32'd910, 0, 0, 0));
    directed_q.push_back(make_tick(1500, 2000, 32'd911, 0, 0, 0));
    directed_q.push_back(make_tick(1500, 1000, 32'd912, 0, 0, 0));
    directed_q.push_back(make_tick(1500, 1500, 32'd913, 0, 0, 0));
    directed_q.push_back(make_tick(2000, 2000, 32'hFFFF_FFF0, 0, 0, 0));
    directed_q.push_back(make_tick(1000, 2000, 32'h0000_0010, 32767, 0, 32767));
    foreach (directed_q[i]) drive_tick(directed_q[i]);
    in_valid_i = 1'b0;
    drain();

    for (int p = 1; p <= Phases; p++) begin
      configure_phase(p);
      if (p == Phases) calm = 1'b1;
      if (p == 3) clock_ms = 32'hFFFF_FF00;
      for (int n = 0; n < RandomTicks / Phases; n++) drive_tick(random_tick());
      in_valid_i = 1'b0;
      drain();
    end

    if (sb.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/rcdd_pkg.sv
src/rcdd_ctrl.sv
src/rcdd_datapath.sv
src/rc_differential_drive_mixer.sv
tb/tb.sv
